>>> hdl/mtfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfw_pkg
// shared types and constants of the move-to-front window list
// ----------------------------------------------------------------------------
package mtfw_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 16;
  localparam int TAB_W     = 16;
  localparam int TAB_CNT_W = $clog2(TAB_W);

  localparam logic ACT_RUN    = 1'b0;
  localparam logic ACT_SWITCH = 1'b1;

  typedef struct packed {
    logic             action;
    logic [ID_W-1:0]  window_id;
    logic [TAB_W-1:0] tab_count;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] selected_id;
    logic            dropped_oldest;
    logic            empty_error;
  } out_word_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic scan;
    logic mtf;
  } cell_ctl_t;

endpackage

>>> hdl/mtfw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfw_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface mtfw_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/mtfw_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfw_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module mtfw_rem import mtfw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [TAB_W-1:0]             dividend,
  input  logic [$clog2(DEPTH+1)-1:0]   divisor,
  output logic                         done,
  output logic [$clog2(DEPTH+1)-1:0]   rem
);
  localparam int CW = $clog2(DEPTH + 1);

  logic                 busy;
  logic [TAB_CNT_W-1:0] cnt;
  logic [TAB_W-1:0]     dsh;
  logic [CW-1:0]        r;
  logic [CW:0]          trial;
  logic [CW:0]          diff;
  logic [CW-1:0]        r_next;

  always_comb begin
    trial  = {r, dsh[TAB_W-1]};
    diff   = trial - {1'b0, divisor};
    r_next = (trial >= {1'b0, divisor}) ? diff[CW-1:0] : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dsh  <= dividend;
        r    <= '0;
      end else if (busy) begin
        r   <= r_next;
        dsh <= {dsh[TAB_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == TAB_CNT_W'(TAB_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r;

endmodule

>>> hdl/mtfw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfw_cell
// one list position: holds an entry and passes the selected id forward
// ----------------------------------------------------------------------------
module mtfw_cell import mtfw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int POS   = 0
) (
  input  logic                       clk,
  input  cell_ctl_t                  ctl,
  input  logic [$clog2(DEPTH)-1:0]   idx,
  input  logic [ID_W-1:0]            prev,
  input  logic [ID_W-1:0]            sel_in,
  output logic [ID_W-1:0]            entry,
  output logic [ID_W-1:0]            sel_out
);
  localparam int IW = $clog2(DEPTH);

  logic hit;
  logic upto;

  assign hit  = (idx == IW'(POS));
  assign upto = (IW'(POS) <= idx);

  always_ff @(posedge clk) begin
    if (ctl.push || (ctl.mtf && upto)) begin
      entry <= prev;
    end
    if (ctl.scan) begin
      sel_out <= hit ? entry : sel_in;
    end
  end

endmodule

>>> hdl/move_to_front_window_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_window_list
// most-recent-first list of window ids kept in a row of cells
// ----------------------------------------------------------------------------
// run word or switch on an empty list: result set from IDLE, output from DONE
// switch word: states DIV, SCAN, MTF, DONE; the selected position p comes
//   from a 16-step remainder unit, then the selected id moves one cell per cycle
// throughput: one word at a time, next word accepted once the result is queued
// reset: list empty, no result pending; entries hold no reset value
// ----------------------------------------------------------------------------
module move_to_front_window_list import mtfw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  mtfw_if.sink   cmd,
  mtfw_if.source rsp
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [2:0] {IDLE, DIV, SCAN, MTF, DONE} state_t;

  state_t        state;
  logic [CW-1:0] occ;
  logic [IW-1:0] idx;
  logic [IW-1:0] cnt;
  out_word_t     res;
  out_word_t     out_word;
  logic          out_valid;

  in_word_t      cw;
  logic          accept;
  logic          rem_start;
  logic          rem_done;
  logic [CW-1:0] rem;
  cell_ctl_t     ctl;
  logic [ID_W-1:0] front;
  logic [ID_W-1:0] ent [DEPTH];
  logic [ID_W-1:0] sel [DEPTH+1];

  assign cw        = cmd.data;
  assign cmd.ready = (state == IDLE) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign rem_start = accept && (cw.action == ACT_SWITCH) && (occ != '0);

  assign ctl.push = accept && (cw.action == ACT_RUN);
  assign ctl.scan = (state == SCAN);
  assign ctl.mtf  = (state == MTF);
  assign front    = ctl.push ? cw.window_id : sel[0];

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  mtfw_rem #(.DEPTH(DEPTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (cw.tab_count),
    .divisor  (occ),
    .done     (rem_done),
    .rem      (rem)
  );

  assign sel[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mtfw_cell #(.DEPTH(DEPTH), .POS(g)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (idx),
      .prev    ((g == 0) ? front : ent[(g == 0) ? 0 : g - 1]),
      .sel_in  (sel[g+1]),
      .entry   (ent[g]),
      .sel_out (sel[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (cw.action == ACT_RUN) begin
              res <= '{selected_id: cw.window_id,
                       dropped_oldest: (occ == CW'(DEPTH)),
                       empty_error: 1'b0};
              if (occ != CW'(DEPTH)) begin
                occ <= occ + 1'b1;
              end
              state <= DONE;
            end else if (occ == '0) begin
              res   <= '{selected_id: '0, dropped_oldest: 1'b0, empty_error: 1'b1};
              state <= DONE;
            end else begin
              res   <= '0;
              state <= DIV;
            end
          end
        end
        DIV: begin
          if (rem_done) begin
            idx   <= rem[IW-1:0];
            cnt   <= rem[IW-1:0];
            state <= SCAN;
          end
        end
        SCAN: begin
          if (cnt == '0) begin
            state <= MTF;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        MTF: begin
          res.selected_id <= sel[0];
          state           <= DONE;
        end
        DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_word  <= res;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= CW'(DEPTH))
    else $error("occupancy above list depth");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == DIV && rem_done) |-> (rem < occ))
    else $error("remainder not below list length");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.dropped_oldest && rsp.data.empty_error))
    else $error("both result flags set");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.empty_error) |-> (rsp.data.selected_id == '0))
    else $error("empty error with nonzero id");

endmodule
